>>> hdl/fra_pkg.sv
// Shared types and constants of the frame ring allocator.
package fra_pkg;

   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 32;
   localparam int STRIDE_W    = 16;
   localparam int PROD_W      = COUNT_W + STRIDE_W;
   localparam int FRAMES_W    = 3;
   localparam int ALIGN_BYTES = 256;
   localparam int ALIGN_W     = $clog2(ALIGN_BYTES);

   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_RING_BYTES       = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES_IN_FLIGHT = 4'd1;

   localparam logic [DATA_W-1:0]   RING_BYTES_RESET = 32'd1048576;
   localparam logic [FRAMES_W-1:0] FRAMES_RESET     = 3'd3;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FRAME = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   typedef enum logic [1:0] {
      MOD_TAIL,
      MOD_FRAME,
      MOD_HEAD
   } mod_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_SIZE,
      ST_TAIL,
      ST_TAIL_WAIT,
      ST_FIT,
      ST_PAD,
      ST_TAKE,
      ST_FR_TAB,
      ST_FR_IDX,
      ST_FR_READ,
      ST_FR_FREE,
      ST_FR_HEAD,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic        load;
      logic        mul;
      logic        size;
      logic        fail;
      logic        tail_zero;
      logic        tail_load;
      logic        fit;
      logic        pad_take;
      logic        take;
      logic        fr_tab;
      logic        fr_idx;
      logic        fr_read;
      logic        fr_free;
      logic        head_load;
      logic        out_load;
      logic        mod_start;
      mod_sel_type mod_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic is_frame;
      logic ovf;
      logic ring_zero;
      logic mod_done;
      logic need_pad;
      logic pad_fits;
      logic take_fits;
      logic free_ok;
      logic out_free;
   } dp_sts_type;

endpackage

>>> hdl/fra_rem.sv
// Bit-serial remainder unit: one quotient bit per cycle, early finish when no reduction is needed.
module fra_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] remainder
);

   localparam int STEPS = 33;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [32:0]      dvd_ff;
   logic [31:0]      dsr_ff;
   logic [31:0]      rem_ff;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        trial_ge;
   logic        fast;

   assign trial    = {rem_ff, dvd_ff[32]};
   assign diff     = trial - {1'b0, dsr_ff};
   assign trial_ge = trial >= {1'b0, dsr_ff};
   assign fast     = dividend < {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (fast) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= CNT_W'(STEPS);
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= fast ? dividend[31:0] : '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[31:0], 1'b0};
         rem_ff <= trial_ge ? diff[31:0] : trial[31:0];
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> hdl/fra_dp.sv
// Datapath of the frame ring allocator: ring state, frame tabs, size arithmetic and result register.
module fra_dp #(
   parameter int MAX_FRAMES = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fra_pkg::dp_cmd_type                cmd,
   output fra_pkg::dp_sts_type                sts,
   input  logic                               csr_write,
   input  logic [fra_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fra_pkg::DATA_W-1:0]         csr_data,
   input  logic                               req_mode,
   input  logic [fra_pkg::COUNT_W-1:0]        req_element_count,
   input  logic [fra_pkg::STRIDE_W-1:0]       req_element_stride,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic                               rsp_status,
   output logic [fra_pkg::DATA_W-1:0]         rsp_offset,
   output logic [fra_pkg::DATA_W-1:0]         rsp_granted_bytes,
   output logic [fra_pkg::DATA_W-1:0]         rsp_freed_bytes
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int DW    = fra_pkg::DATA_W;

   // Configuration registers.
   logic [DW-1:0]                ring_ff;
   logic [fra_pkg::FRAMES_W-1:0] fif_ff;

   // Allocator state.
   logic [DW-1:0]    head_ff;
   logic [DW-1:0]    used_ff;
   logic [IDX_W-1:0] fidx_ff;
   logic [DW-1:0]    btf_ff;
   logic [DW-1:0]    tabs_ff [MAX_FRAMES];

   // Per-item working registers.
   logic                         mode_ff;
   logic [fra_pkg::COUNT_W-1:0]  count_ff;
   logic [fra_pkg::STRIDE_W-1:0] stride_ff;
   logic [fra_pkg::PROD_W-1:0]   prod_ff;
   logic [DW-1:0]                size_ff;
   logic                         ovf_ff;
   logic [DW-1:0]                tail_ff;
   logic [DW-1:0]                pad_ff;
   logic [DW-1:0]                tab_ff;
   logic                         res_status_ff;
   logic [DW-1:0]                res_offset_ff;
   logic [DW-1:0]                res_granted_ff;
   logic [DW-1:0]                res_freed_ff;

   logic          rsp_valid_ff;
   logic          rsp_status_ff;
   logic [DW-1:0] rsp_offset_ff;
   logic [DW-1:0] rsp_granted_ff;
   logic [DW-1:0] rsp_freed_ff;

   logic [fra_pkg::PROD_W:0] rounded;
   logic [DW:0]              used_pad;
   logic [DW:0]              used_size;
   logic [DW-1:0]            add_amt;
   logic [DW:0]              btf_sum;
   logic [DW-1:0]            frames_eff;
   logic [DW-1:0]            frames_max;
   logic [DW-1:0]            fif_wide;
   logic [32:0]              mod_dividend;
   logic [31:0]              mod_divisor;
   logic                     mod_done;
   logic [31:0]              mod_rem;

   assign rounded = {1'b0, prod_ff} + (fra_pkg::PROD_W + 1)'(fra_pkg::ALIGN_BYTES - 1);

   assign used_pad  = {1'b0, used_ff} + {1'b0, pad_ff};
   assign used_size = {1'b0, used_ff} + {1'b0, size_ff};
   assign add_amt   = cmd.pad_take ? pad_ff : size_ff;
   assign btf_sum   = {1'b0, btf_ff} + {1'b0, add_amt};

   // Frame count clamped into 1 .. MAX_FRAMES.
   assign fif_wide   = DW'(fif_ff);
   assign frames_max = DW'(MAX_FRAMES);
   assign frames_eff = (fif_ff == '0) ? DW'(1) :
                       ((fif_wide > frames_max) ? frames_max : fif_wide);

   always_comb begin
      unique case (cmd.mod_sel)
         fra_pkg::MOD_TAIL: begin
            mod_dividend = {1'b0, head_ff} + {1'b0, used_ff};
            mod_divisor  = ring_ff;
         end
         fra_pkg::MOD_FRAME: begin
            mod_dividend = 33'(fidx_ff) + 33'd1;
            mod_divisor  = frames_eff;
         end
         fra_pkg::MOD_HEAD: begin
            mod_dividend = {1'b0, head_ff} + {1'b0, tab_ff};
            mod_divisor  = ring_ff;
         end
         default: begin
            mod_dividend = '0;
            mod_divisor  = ring_ff;
         end
      endcase
   end

   fra_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      sts.is_frame  = (mode_ff == fra_pkg::MODE_FRAME);
      sts.ovf       = ovf_ff;
      sts.ring_zero = (ring_ff == '0);
      sts.mod_done  = mod_done;
      sts.need_pad  = (size_ff > pad_ff) && (pad_ff != '0);
      sts.pad_fits  = used_pad <= {1'b0, ring_ff};
      sts.take_fits = used_size <= {1'b0, ring_ff};
      sts.free_ok   = used_ff >= tab_ff;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Configuration and allocator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= fra_pkg::RING_BYTES_RESET;
         fif_ff  <= fra_pkg::FRAMES_RESET;
         head_ff <= '0;
         used_ff <= '0;
         fidx_ff <= '0;
         btf_ff  <= '0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            tabs_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               fra_pkg::CSR_RING_BYTES:       ring_ff <= csr_data;
               fra_pkg::CSR_FRAMES_IN_FLIGHT: fif_ff  <= csr_data[fra_pkg::FRAMES_W-1:0];
               default: ;
            endcase
         end
         if (cmd.pad_take) begin
            used_ff <= used_pad[DW-1:0];
         end
         if (cmd.take) begin
            used_ff <= used_size[DW-1:0];
         end
         if (cmd.pad_take || cmd.take) begin
            btf_ff <= btf_sum[DW] ? '1 : btf_sum[DW-1:0];
         end
         if (cmd.fr_tab) begin
            tabs_ff[fidx_ff] <= btf_ff;
            btf_ff           <= '0;
         end
         if (cmd.fr_idx) begin
            fidx_ff <= mod_rem[IDX_W-1:0];
         end
         if (cmd.fr_free) begin
            used_ff <= used_ff - tab_ff;
         end
         if (cmd.head_load) begin
            head_ff <= mod_rem;
         end
      end
   end

   // Working registers of the item in progress.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff        <= req_mode;
         count_ff       <= req_element_count;
         stride_ff      <= req_element_stride;
         res_status_ff  <= fra_pkg::STATUS_OK;
         res_offset_ff  <= '0;
         res_granted_ff <= '0;
         res_freed_ff   <= '0;
      end
      if (cmd.mul) begin
         prod_ff <= count_ff * stride_ff;
      end
      if (cmd.size) begin
         size_ff <= {rounded[DW-1:fra_pkg::ALIGN_W], {fra_pkg::ALIGN_W{1'b0}}};
         ovf_ff  <= |rounded[fra_pkg::PROD_W:DW];
      end
      if (cmd.tail_zero) begin
         tail_ff <= '0;
      end
      if (cmd.tail_load) begin
         tail_ff <= mod_rem;
      end
      if (cmd.fit) begin
         pad_ff <= ring_ff - tail_ff;
      end
      // Once the padding is taken the tail sits at the start of the ring.
      if (cmd.pad_take) begin
         tail_ff <= '0;
      end
      if (cmd.take) begin
         res_offset_ff  <= tail_ff;
         res_granted_ff <= size_ff;
      end
      if (cmd.fail) begin
         res_status_ff <= fra_pkg::STATUS_OOM;
      end
      if (cmd.fr_read) begin
         tab_ff <= tabs_ff[fidx_ff];
      end
      if (cmd.fr_free) begin
         res_freed_ff <= tab_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_offset_ff  <= res_offset_ff;
         rsp_granted_ff <= res_granted_ff;
         rsp_freed_ff   <= res_freed_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_offset        = rsp_offset_ff;
   assign rsp_granted_bytes = rsp_granted_ff;
   assign rsp_freed_bytes   = rsp_freed_ff;

endmodule

>>> hdl/fra_ctrl.sv
// Controller state machine of the frame ring allocator.
module fra_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fra_pkg::dp_sts_type sts,
   output fra_pkg::dp_cmd_type cmd
);

   fra_pkg::ctrl_state_type state_ff;
   fra_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mod_sel = fra_pkg::MOD_TAIL;
      req_stall   = 1'b1;
      unique case (state_ff)
         fra_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = fra_pkg::ST_START;
            end
         end
         fra_pkg::ST_START: begin
            state_in = sts.is_frame ? fra_pkg::ST_FR_TAB : fra_pkg::ST_MUL;
         end
         fra_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = fra_pkg::ST_SIZE;
         end
         fra_pkg::ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = fra_pkg::ST_TAIL;
         end
         fra_pkg::ST_TAIL: begin
            if (sts.ovf) begin
               cmd.fail = 1'b1;
               state_in = fra_pkg::ST_OUT;
            end else if (sts.ring_zero) begin
               cmd.tail_zero = 1'b1;
               state_in      = fra_pkg::ST_FIT;
            end else begin
               cmd.mod_start = 1'b1;
               cmd.mod_sel   = fra_pkg::MOD_TAIL;
               state_in      = fra_pkg::ST_TAIL_WAIT;
            end
         end
         fra_pkg::ST_TAIL_WAIT: begin
            if (sts.mod_done) begin
               cmd.tail_load = 1'b1;
               state_in      = fra_pkg::ST_FIT;
            end
         end
         fra_pkg::ST_FIT: begin
            cmd.fit  = 1'b1;
            state_in = fra_pkg::ST_PAD;
         end
         fra_pkg::ST_PAD: begin
            state_in = fra_pkg::ST_TAKE;
            if (sts.need_pad) begin
               if (sts.pad_fits) begin
                  cmd.pad_take = 1'b1;
               end else begin
                  cmd.fail = 1'b1;
                  state_in = fra_pkg::ST_OUT;
               end
            end
         end
         fra_pkg::ST_TAKE: begin
            if (sts.take_fits) begin
               cmd.take = 1'b1;
            end else begin
               cmd.fail = 1'b1;
            end
            state_in = fra_pkg::ST_OUT;
         end
         fra_pkg::ST_FR_TAB: begin
            cmd.fr_tab    = 1'b1;
            cmd.mod_start = 1'b1;
            cmd.mod_sel   = fra_pkg::MOD_FRAME;
            state_in      = fra_pkg::ST_FR_IDX;
         end
         fra_pkg::ST_FR_IDX: begin
            if (sts.mod_done) begin
               cmd.fr_idx = 1'b1;
               state_in   = fra_pkg::ST_FR_READ;
            end
         end
         fra_pkg::ST_FR_READ: begin
            cmd.fr_read = 1'b1;
            state_in    = fra_pkg::ST_FR_FREE;
         end
         fra_pkg::ST_FR_FREE: begin
            state_in = fra_pkg::ST_OUT;
            if (sts.free_ok) begin
               cmd.fr_free = 1'b1;
               // With a ring size of zero the head does not move.
               if (!sts.ring_zero) begin
                  cmd.mod_start = 1'b1;
                  cmd.mod_sel   = fra_pkg::MOD_HEAD;
                  state_in      = fra_pkg::ST_FR_HEAD;
               end
            end
         end
         fra_pkg::ST_FR_HEAD: begin
            cmd.mod_sel = fra_pkg::MOD_HEAD;
            if (sts.mod_done) begin
               cmd.head_load = 1'b1;
               state_in      = fra_pkg::ST_OUT;
            end
         end
         fra_pkg::ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = fra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fra_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/frame_ring_allocator.sv
// Frame ring allocator: a byte allocator over a ring that releases space once per frame.
//
// Requests arrive on the req_ channel (valid/stall). Mode 0 allocates element_count times
// element_stride bytes rounded up to 256; mode 1 closes the current frame and releases the
// tab of the frame it moves into. Each request gives exactly one transfer on the rsp_
// channel carrying status, offset, granted_bytes and freed_bytes.
// The block works on one request at a time. An allocation steps through MUL and SIZE,
// one pass of the remainder unit that reduces head plus used modulo the ring size, then
// FIT, PAD and TAKE before the result register loads; an oversized request skips the
// pass and goes straight to the result, and a zero ring sets a zero tail instead of it.
// A frame request steps through FR_TAB, a pass for the frame index, FR_READ and FR_FREE,
// then a second pass for the head when the tab is freed and the ring size is not zero.
// A pass ends early when the value is below the divisor; otherwise the unit retires one
// quotient bit per cycle. The next request is taken in the cycle after the result loads.
// A finished result waits in the output register while the next request is accepted;
// when rsp_stall holds, a second result cannot load and req_stall stays high until the
// first one transfers.
// Reset clears the ring state and all frame tabs at once and restores the configuration
// (ring of 1 MiB, 3 frames in flight). Configuration writes on the csr_ channel are
// always ready and are meant for times when no request is in flight.
module frame_ring_allocator #(
   parameter int MAX_FRAMES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [fra_pkg::COUNT_W-1:0]     req_element_count,
   input  logic [fra_pkg::STRIDE_W-1:0]    req_element_stride,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_status,
   output logic [fra_pkg::DATA_W-1:0]      rsp_offset,
   output logic [fra_pkg::DATA_W-1:0]      rsp_granted_bytes,
   output logic [fra_pkg::DATA_W-1:0]      rsp_freed_bytes,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fra_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fra_pkg::DATA_W-1:0]      csr_data
);

   fra_pkg::dp_cmd_type cmd;
   fra_pkg::dp_sts_type sts;

   assign csr_ready = 1'b1;

   fra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fra_dp #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_mode           (req_mode),
      .req_element_count  (req_element_count),
      .req_element_stride (req_element_stride),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_offset         (rsp_offset),
      .rsp_granted_bytes  (rsp_granted_bytes),
      .rsp_freed_bytes    (rsp_freed_bytes)
   );

endmodule
